FILE: hw/rtl/bts_pkg.sv
// Shared constants and types for the bilinear texture sampler.
// Used by the top level, bts_coord and bts_blend; no dependencies.
`timescale 1ns / 1ps

package bts_pkg;

	localparam int TEXEL_W  = 24;
	localparam int CHAN_W   = 8;
	localparam int CHANNELS = 3;
	localparam int CFG_W    = 9;
	localparam int COORD_W  = 20;
	localparam int PIX_W    = 8;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

	// item kinds
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// what an item does once it reaches the store
	typedef struct packed {
		logic sample;
		logic write;
	} stage_ctl_t;

endpackage

FILE: hw/rtl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: input register, texel store,
// coordinate and blend stages. Depends on bts_pkg, bts_coord, bts_ram, bts_blend.
`timescale 1ns / 1ps

// Takes one word per cycle while in_stall is low and returns a sample
// result from the last stage; writes give no result. The five stages are
// input register, coordinate scale (one multiply per axis), store read,
// horizontal lerp and vertical lerp with rounding. The store is held as four
// copies of 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) x 24 bits so the four
// neighbors are read together; every write goes to all copies. The whole
// pipeline moves together: it halts only while a finished result sits at the
// output and out_stall is high, and in that cycle in_stall is high. Texels
// must be written before they are sampled.
module bilinear_texture_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [7:0]                    texel_x,
	input  logic [7:0]                    texel_y,
	input  logic [bts_pkg::TEXEL_W-1:0]   texel_bgr,
	input  logic [bts_pkg::COORD_W-1:0]   coord_u,
	input  logic [bts_pkg::COORD_W-1:0]   coord_v,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bts_pkg::PIX_W-1:0]     red,
	output logic [bts_pkg::PIX_W-1:0]     green,
	output logic [bts_pkg::PIX_W-1:0]     blue,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bts_pkg::CFG_W-1:0]     cfg_data
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;

	logic en;
	logic [bts_pkg::CFG_W-1:0] width_q, height_q;

	logic                        valid_s1, op_s1;
	logic [7:0]                  tx_s1, ty_s1;
	logic [bts_pkg::TEXEL_W-1:0] bgr_s1;
	logic [bts_pkg::COORD_W-1:0] cu_s1, cv_s1;

	bts_pkg::stage_ctl_t         ctl;
	logic [AW-1:0]               waddr, ra00, ra10, ra01, ra11;
	logic [bts_pkg::TEXEL_W-1:0] wdata, c00, c10, c01, c11, bgr_out;
	logic [FRAC_BITS-1:0]        fx, fy, fx_s3, fy_s3;
	logic                        valid_s3;

	// pipeline advances unless a result is held at the output
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bts_pkg::SIZE_RESET;
			height_q <= bts_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bts_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bts_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= operation;
			tx_s1  <= texel_x;
			ty_s1  <= texel_y;
			bgr_s1 <= texel_bgr;
			cu_s1  <= coord_u;
			cv_s1  <= coord_v;
		end
	end

	bts_coord #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s1(valid_s1),
		.op_s1   (op_s1),
		.tx_s1   (tx_s1),
		.ty_s1   (ty_s1),
		.bgr_s1  (bgr_s1),
		.cu_s1   (cu_s1),
		.cv_s1   (cv_s1),
		.width_q (width_q),
		.height_q(height_q),
		.ctl     (ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr00 (ra00),
		.raddr10 (ra10),
		.raddr01 (ra01),
		.raddr11 (ra11),
		.fx      (fx),
		.fy      (fy)
	);

	// four store copies, one per neighbor; writes land in the same stage
	// as reads so items see the store in order
	bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram00 (
		.clk(clk), .we(en && ctl.write), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(ra00), .rdata(c00)
	);
	bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram10 (
		.clk(clk), .we(en && ctl.write), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(ra10), .rdata(c10)
	);
	bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram01 (
		.clk(clk), .we(en && ctl.write), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(ra01), .rdata(c01)
	);
	bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram11 (
		.clk(clk), .we(en && ctl.write), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(ra11), .rdata(c11)
	);

	// control traveling alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= ctl.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s3 <= fx;
			fy_s3 <= fy;
		end
	end

	bts_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s3(valid_s3),
		.c00     (c00),
		.c10     (c10),
		.c01     (c01),
		.c11     (c11),
		.fx_s3   (fx_s3),
		.fy_s3   (fy_s3),
		.valid   (out_valid),
		.bgr     (bgr_out)
	);

	assign red   = bgr_out[23:16];
	assign green = bgr_out[15:8];
	assign blue  = bgr_out[7:0];

endmodule

FILE: hw/rtl/bts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/bts_coord.sv
// Coordinate stage: scales (u,v) by the texture size, splits integer and
// fraction, and forms the four neighbor addresses. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_coord #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 16,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT),
	localparam int AW = XW + YW
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid_s1,
	input  logic                            op_s1,
	input  logic [7:0]                      tx_s1,
	input  logic [7:0]                      ty_s1,
	input  logic [bts_pkg::TEXEL_W-1:0]     bgr_s1,
	input  logic [bts_pkg::COORD_W-1:0]     cu_s1,
	input  logic [bts_pkg::COORD_W-1:0]     cv_s1,
	input  logic [bts_pkg::CFG_W-1:0]       width_q,
	input  logic [bts_pkg::CFG_W-1:0]       height_q,
	output bts_pkg::stage_ctl_t             ctl,
	output logic [AW-1:0]                   waddr,
	output logic [bts_pkg::TEXEL_W-1:0]     wdata,
	output logic [AW-1:0]                   raddr00,
	output logic [AW-1:0]                   raddr10,
	output logic [AW-1:0]                   raddr01,
	output logic [AW-1:0]                   raddr11,
	output logic [FRAC_BITS-1:0]            fx,
	output logic [FRAC_BITS-1:0]            fy
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PX = FRAC_BITS + WW;
	localparam int PY = FRAC_BITS + HW;

	logic [WW-1:0]        w;
	logic [HW-1:0]        h;
	logic [FRAC_BITS-1:0] fu, fv;
	logic                 in_range;

	bts_pkg::stage_ctl_t        ctl_s2;
	logic [PX-1:0]              xp_s2;
	logic [PY-1:0]              yp_s2;
	logic [AW-1:0]              waddr_s2;
	logic [bts_pkg::TEXEL_W-1:0] wdata_s2;

	logic [XW-1:0] x1, x2;
	logic [YW-1:0] y1, y2;

	// size in use, with zero taken as one and oversize taken as the maximum
	always_comb begin
		if (width_q == '0) begin
			w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_q);
		end
		if (height_q == '0) begin
			h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(height_q);
		end
	end

	// (u*w) mod (w<<F) equals (u mod 1.0)*w, so only the fraction is scaled
	assign fu = FRAC_BITS'($signed(cu_s1));
	assign fv = FRAC_BITS'($signed(cv_s1));
	assign in_range = (32'(tx_s1) < 32'(MAX_WIDTH)) && (32'(ty_s1) < 32'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.sample <= valid_s1 && (op_s1 == bts_pkg::OP_SAMPLE);
			ctl_s2.write  <= valid_s1 && (op_s1 == bts_pkg::OP_WRITE) && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2    <= PX'(fu) * PX'(w);
			yp_s2    <= PY'(fv) * PY'(h);
			waddr_s2 <= {YW'(ty_s1), XW'(tx_s1)};
			wdata_s2 <= bgr_s1;
		end
	end

	// neighbors: horizontal wraps to column 0, vertical clamps at last row
	assign x1 = xp_s2[FRAC_BITS +: XW];
	assign y1 = yp_s2[FRAC_BITS +: YW];
	assign x2 = (32'(x1) + 32'd1 == 32'(w)) ? '0 : x1 + 1'b1;
	assign y2 = (32'(y1) + 32'd1 == 32'(h)) ? y1 : y1 + 1'b1;

	assign ctl     = ctl_s2;
	assign waddr   = waddr_s2;
	assign wdata   = wdata_s2;
	assign raddr00 = {y1, x1};
	assign raddr10 = {y1, x2};
	assign raddr01 = {y2, x1};
	assign raddr11 = {y2, x2};
	assign fx      = xp_s2[FRAC_BITS-1:0];
	assign fy      = yp_s2[FRAC_BITS-1:0];

endmodule

FILE: hw/rtl/bts_blend.sv
// Blend stages: horizontal lerp, then vertical lerp with round-half-up.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_s3,
	input  logic [bts_pkg::TEXEL_W-1:0] c00,
	input  logic [bts_pkg::TEXEL_W-1:0] c10,
	input  logic [bts_pkg::TEXEL_W-1:0] c01,
	input  logic [bts_pkg::TEXEL_W-1:0] c11,
	input  logic [FRAC_BITS-1:0]        fx_s3,
	input  logic [FRAC_BITS-1:0]        fy_s3,
	output logic                        valid,
	output logic [bts_pkg::TEXEL_W-1:0] bgr
);

	localparam int FB = FRAC_BITS;
	localparam int CW = bts_pkg::CHAN_W;
	localparam int TW = FB + CW;
	localparam logic [2*FB+9:0] RND = (2*FB+10)'(1) << (2*FB - 1);

	logic                 valid_s4, valid_s5;
	logic [TW-1:0]        top_s4 [bts_pkg::CHANNELS];
	logic [TW-1:0]        bot_s4 [bts_pkg::CHANNELS];
	logic [FB-1:0]        fy_s4;
	logic [CW-1:0]        chan_s5 [bts_pkg::CHANNELS];

	logic [TW-1:0]        top_n [bts_pkg::CHANNELS];
	logic [TW-1:0]        bot_n [bts_pkg::CHANNELS];
	logic [CW-1:0]        chan_n [bts_pkg::CHANNELS];

	// horizontal: a*S + (b-a)*fx per lane
	always_comb begin
		logic signed [CW:0]     dt, db;
		logic signed [FB+9:0]   pt, pb, st, sb;
		for (int i = 0; i < bts_pkg::CHANNELS; i++) begin
			dt = $signed({1'b0, c10[CW*i +: CW]}) - $signed({1'b0, c00[CW*i +: CW]});
			db = $signed({1'b0, c11[CW*i +: CW]}) - $signed({1'b0, c01[CW*i +: CW]});
			pt = dt * $signed({1'b0, fx_s3});
			pb = db * $signed({1'b0, fx_s3});
			st = $signed({2'b00, c00[CW*i +: CW], {FB{1'b0}}}) + pt;
			sb = $signed({2'b00, c01[CW*i +: CW], {FB{1'b0}}}) + pb;
			top_n[i] = st[TW-1:0];
			bot_n[i] = sb[TW-1:0];
		end
	end

	// vertical: top*S + (bot-top)*fy, rounded, scaled down by 2F
	always_comb begin
		logic signed [TW:0]      dv;
		logic signed [2*FB+9:0]  pv, sv;
		for (int i = 0; i < bts_pkg::CHANNELS; i++) begin
			dv = $signed({1'b0, bot_s4[i]}) - $signed({1'b0, top_s4[i]});
			pv = dv * $signed({1'b0, fy_s4});
			sv = $signed({2'b00, top_s4[i], {FB{1'b0}}}) + pv + $signed(RND);
			chan_n[i] = sv[2*FB +: CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s4  <= top_n;
			bot_s4  <= bot_n;
			fy_s4   <= fy_s3;
			chan_s5 <= chan_n;
		end
	end

	assign valid = valid_s5;
	assign bgr   = {chan_s5[2], chan_s5[1], chan_s5[0]};

endmodule

FILE: hw/rtl/bts_checker.sv
// Port-level checks for the bilinear texture sampler, bound to the top level.
// Depends on bilinear_texture_sampler.
`timescale 1ns / 1ps

module bts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// a held result stays and keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("output word changed while stalled");

	// a blocked output backs up the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");

	// no result waiting means no stall toward the source
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.red      (red),
	.green    (green),
	.blue     (blue)
);
